/* sv/grr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grr_pkg
// Shared sizes, operation and register codes, and the command and status
// bundles between the row reweighter controller and datapath.
// ----------------------------------------------------------------------------
package grr_pkg;

    localparam int MAX_ROWS      = 64;
    localparam int ROW_BITS      = $clog2(MAX_ROWS);
    localparam int CNT_BITS      = $clog2(MAX_ROWS + 1);
    localparam int MASK_BITS     = 64;
    localparam int WEIGHT_BITS   = 16;
    localparam int WIN_BITS      = 7;
    localparam int TOTAL_BITS    = 32;
    localparam int OP_BITS       = 2;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [OP_BITS-1:0] {
        OP_LOAD_WEIGHT  = 2'd0,
        OP_START_WINDOW = 2'd1,
        OP_CANDIDATE    = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW_ROWS = 1'b0,
        CFG_MIN_GAIN    = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_NONE,
        PH_PAR,
        PH_SEL,
        PH_UPD
    } t_phase;

    typedef struct packed {
        logic   in_ready;
        logic   wr_weight;
        logic   start_win;
        logic   capture;
        logic   idx_clr;
        t_phase phase;
        logic   fetch;
        logic   load_out;
    } t_cmd;

    typedef struct packed {
        logic               in_valid;
        logic [OP_BITS-1:0] in_op;
        logic               phase_done;
        logic               found;
        logic               out_free;
    } t_status;

endpackage

/* sv/grr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grr_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface grr_item_if;
    import grr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OP_BITS-1:0]     operation;
    logic [ROW_BITS-1:0]    row_index;
    logic [WEIGHT_BITS-1:0] row_weight;
    logic [MASK_BITS-1:0]   candidate_mask;
    logic [WEIGHT_BITS-1:0] cand_weight;

    modport source (
        output valid, operation, row_index, row_weight, candidate_mask, cand_weight,
        input  ready
    );
    modport sink (
        input  valid, operation, row_index, row_weight, candidate_mask, cand_weight,
        output ready
    );
endinterface

interface grr_result_if;
    import grr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   applied;
    logic [ROW_BITS-1:0]    chosen_row;
    logic [MASK_BITS-1:0]   xor_sources;
    logic [WEIGHT_BITS-1:0] gain;
    logic [TOTAL_BITS-1:0]  applied_total;
    logic [TOTAL_BITS-1:0]  improvement_total;

    modport source (
        output valid, applied, chosen_row, xor_sources, gain, applied_total,
               improvement_total,
        input  ready
    );
    modport sink (
        input  valid, applied, chosen_row, xor_sources, gain, applied_total,
               improvement_total,
        output ready
    );
endinterface

/* sv/grr_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grr_controller
// Sequences one item: decode on transfer; for a candidate, parity and select
// phases, then fetch and update phases when a row is chosen, then result.
// ----------------------------------------------------------------------------
module grr_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  grr_pkg::t_status  i_status,
    output grr_pkg::t_cmd     o_cmd
);
    import grr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAR,
        S_SEL,
        S_FETCH,
        S_UPD,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    unique case (i_status.in_op)
                        OP_LOAD_WEIGHT:  o_cmd.wr_weight = 1'b1;
                        OP_START_WINDOW: o_cmd.start_win = 1'b1;
                        OP_CANDIDATE: begin
                            o_cmd.capture = 1'b1;
                            o_cmd.idx_clr = 1'b1;
                            n_state       = S_PAR;
                        end
                        default: ;
                    endcase
                end
            end
            S_PAR: begin
                o_cmd.phase = PH_PAR;
                if (i_status.phase_done) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_SEL;
                end
            end
            S_SEL: begin
                o_cmd.phase = PH_SEL;
                if (i_status.phase_done) begin
                    n_state = i_status.found ? S_FETCH : S_OUT;
                end
            end
            S_FETCH: begin
                o_cmd.fetch   = 1'b1;
                o_cmd.idx_clr = 1'b1;
                n_state       = S_UPD;
            end
            S_UPD: begin
                o_cmd.phase = PH_UPD;
                if (i_status.phase_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/grr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grr_datapath
// Transform and weight memories, row scan counter, parity, best-row select,
// row fold, saturating totals and the result register.
// ----------------------------------------------------------------------------
module grr_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  grr_pkg::t_cmd                      i_cmd,
    output grr_pkg::t_status                   o_status,
    input  logic                               i_cfg_we,
    input  logic [grr_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [grr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    grr_item_if.sink                           i_item,
    grr_result_if.source                       o_result
);
    import grr_pkg::*;

    logic [WIN_BITS-1:0]    r_window;
    logic [WEIGHT_BITS-1:0] r_min_gain;
    logic [CNT_BITS-1:0]    r_start_n;

    logic [MASK_BITS-1:0]   r_tr_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0]    r_tr_vld;
    logic [WEIGHT_BITS-1:0] r_wt_mem [MAX_ROWS];

    logic [MASK_BITS-1:0]   r_tr_q;
    logic                   r_tr_qv;
    logic [ROW_BITS-1:0]    r_tr_qa;
    logic [WEIGHT_BITS-1:0] r_wt_q;

    logic [CNT_BITS-1:0]    r_idx;
    logic                   r_pipe_v;
    logic [ROW_BITS-1:0]    r_pipe_row;
    logic                   r_fetch_d;

    logic [MASK_BITS-1:0]   r_mask;
    logic [WEIGHT_BITS-1:0] r_cw;
    logic [MASK_BITS-1:0]   r_set;
    logic                   r_found;
    logic [WEIGHT_BITS-1:0] r_best;
    logic [ROW_BITS-1:0]    r_chosen;
    logic [MASK_BITS-1:0]   r_chosen_data;

    logic [TOTAL_BITS-1:0]  r_applied_cnt;
    logic [TOTAL_BITS-1:0]  r_impr_sum;

    logic                   r_out_v;
    logic                   r_out_applied;
    logic [ROW_BITS-1:0]    r_out_row;
    logic [MASK_BITS-1:0]   r_out_src;
    logic [WEIGHT_BITS-1:0] r_out_gain;
    logic [TOTAL_BITS-1:0]  r_out_cnt;
    logic [TOTAL_BITS-1:0]  r_out_sum;

    logic [CNT_BITS-1:0]    act_n;
    logic                   issue;
    logic [ROW_BITS-1:0]    tr_raddr;
    logic [MASK_BITS-1:0]   eff_row;
    logic [MASK_BITS-1:0]   sources;
    logic [WEIGHT_BITS-1:0] gain_cand;
    logic                   sel_take;
    logic                   upd_we;
    logic [MASK_BITS-1:0]   upd_data;
    logic                   wt_we;
    logic [ROW_BITS-1:0]    wt_waddr;
    logic [WEIGHT_BITS-1:0] wt_wdata;
    logic [TOTAL_BITS:0]    cnt_sum;
    logic [TOTAL_BITS:0]    impr_sum;
    logic [TOTAL_BITS-1:0]  n_applied_cnt;
    logic [TOTAL_BITS-1:0]  n_impr_sum;
    logic                   out_free;

    assign act_n    = (r_window > WIN_BITS'(MAX_ROWS)) ? CNT_BITS'(MAX_ROWS)
                                                       : CNT_BITS'(r_window);
    assign issue    = (i_cmd.phase != PH_NONE) && (r_idx < act_n);
    assign tr_raddr = i_cmd.fetch ? r_chosen : r_idx[ROW_BITS-1:0];

    // unwritten rows read as their window-start value
    assign eff_row  = r_tr_qv ? r_tr_q :
                      (({1'b0, r_tr_qa} < r_start_n) ? (MASK_BITS'(1) << r_tr_qa)
                                                      : '0);
    assign sources  = r_set & ~(MASK_BITS'(1) << r_chosen);

    assign gain_cand = r_wt_q - r_cw;
    assign sel_take  = (i_cmd.phase == PH_SEL) && r_pipe_v && r_set[r_pipe_row]
                       && (r_wt_q > r_cw) && (gain_cand >= r_min_gain)
                       && (!r_found || (gain_cand > r_best));

    assign upd_we   = (i_cmd.phase == PH_UPD) && r_pipe_v && sources[r_pipe_row];
    assign upd_data = eff_row ^ r_chosen_data;

    assign wt_we    = i_cmd.wr_weight || (i_cmd.load_out && r_found);
    assign wt_waddr = i_cmd.wr_weight ? i_item.row_index : r_chosen;
    assign wt_wdata = i_cmd.wr_weight ? i_item.row_weight : r_cw;

    assign cnt_sum  = {1'b0, r_applied_cnt} + (TOTAL_BITS+1)'(1);
    assign impr_sum = {1'b0, r_impr_sum} + (TOTAL_BITS+1)'(r_best);

    always_comb begin
        n_applied_cnt = r_applied_cnt;
        n_impr_sum    = r_impr_sum;
        if (r_found) begin
            n_applied_cnt = cnt_sum[TOTAL_BITS] ? '1 : cnt_sum[TOTAL_BITS-1:0];
            n_impr_sum    = impr_sum[TOTAL_BITS] ? '1 : impr_sum[TOTAL_BITS-1:0];
        end
    end

    assign out_free = !r_out_v || o_result.ready;

    assign i_item.ready        = i_cmd.in_ready;
    assign o_status.in_valid   = i_item.valid;
    assign o_status.in_op      = i_item.operation;
    assign o_status.phase_done = (r_idx >= act_n) && !r_pipe_v;
    assign o_status.found      = r_found;
    assign o_status.out_free   = out_free;

    assign o_result.valid             = r_out_v;
    assign o_result.applied           = r_out_applied;
    assign o_result.chosen_row        = r_out_row;
    assign o_result.xor_sources       = r_out_src;
    assign o_result.gain              = r_out_gain;
    assign o_result.applied_total     = r_out_cnt;
    assign o_result.improvement_total = r_out_sum;

    always_ff @(posedge i_clk) begin
        if (upd_we) begin
            r_tr_mem[r_pipe_row] <= upd_data;
        end
        r_tr_q  <= r_tr_mem[tr_raddr];
        r_tr_qa <= tr_raddr;
        if (wt_we) begin
            r_wt_mem[wt_waddr] <= wt_wdata;
        end
        r_wt_q <= r_wt_mem[r_idx[ROW_BITS-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_pipe_row <= r_idx[ROW_BITS-1:0];
        if (i_cmd.capture) begin
            r_mask <= i_item.candidate_mask;
            r_cw   <= i_item.cand_weight;
        end
        if (r_fetch_d) begin
            r_chosen_data <= eff_row;
        end
        if (i_cmd.load_out) begin
            r_out_applied <= r_found;
            r_out_row     <= r_found ? r_chosen : '0;
            r_out_src     <= r_found ? sources : '0;
            r_out_gain    <= r_found ? r_best : '0;
            r_out_cnt     <= n_applied_cnt;
            r_out_sum     <= n_impr_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window      <= WIN_BITS'(MAX_ROWS);
            r_min_gain    <= '0;
            r_start_n     <= CNT_BITS'(MAX_ROWS);
            r_tr_vld      <= '0;
            r_tr_qv       <= 1'b0;
            r_idx         <= '0;
            r_pipe_v      <= 1'b0;
            r_fetch_d     <= 1'b0;
            r_set         <= '0;
            r_found       <= 1'b0;
            r_best        <= '0;
            r_chosen      <= '0;
            r_applied_cnt <= '0;
            r_impr_sum    <= '0;
            r_out_v       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WINDOW_ROWS: r_window   <= i_cfg_data[WIN_BITS-1:0];
                    CFG_MIN_GAIN:    r_min_gain <= i_cfg_data[WEIGHT_BITS-1:0];
                    default: ;
                endcase
            end

            r_tr_qv <= r_tr_vld[tr_raddr];
            if (i_cmd.start_win) begin
                r_tr_vld      <= '0;
                r_start_n     <= act_n;
                r_applied_cnt <= '0;
                r_impr_sum    <= '0;
            end else if (upd_we) begin
                r_tr_vld[r_pipe_row] <= 1'b1;
            end

            r_pipe_v  <= issue;
            r_fetch_d <= i_cmd.fetch;
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (issue) begin
                r_idx <= r_idx + CNT_BITS'(1);
            end

            if (i_cmd.capture) begin
                r_set   <= '0;
                r_found <= 1'b0;
                r_best  <= '0;
                r_chosen <= '0;
            end else begin
                if ((i_cmd.phase == PH_PAR) && r_pipe_v) begin
                    r_set[r_pipe_row] <= ^(r_mask & eff_row);
                end
                if (sel_take) begin
                    r_found  <= 1'b1;
                    r_best   <= gain_cand;
                    r_chosen <= r_pipe_row;
                end
            end

            if (i_cmd.load_out) begin
                r_applied_cnt <= n_applied_cnt;
                r_impr_sum    <= n_impr_sum;
                r_out_v       <= 1'b1;
            end else if (o_result.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> out_free)
        else $error("result loaded while previous result still pending");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= CNT_BITS'(MAX_ROWS))
        else $error("row scan counter beyond row count");

    a_src_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_applied) |-> !r_out_src[r_out_row])
        else $error("chosen row listed among its own xor sources");

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_applied) |->
            ((r_out_src == '0) && (r_out_gain == '0) && (r_out_row == '0)))
        else $error("skipped result carries nonzero fields");

    a_upd_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.phase == PH_UPD) |-> r_found)
        else $error("row update without a chosen row");

endmodule

/* sv/gf2_greedy_row_reweighter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_greedy_row_reweighter
// A load-weight or start-window item takes effect at its transfer edge.
// A candidate runs a parity scan and a select scan over the active rows,
// then, when a row is chosen, a fetch of that row and an update scan, and
// last a result load. No new item is taken until the candidate's result
// is loaded, and the load waits for the result register to free.
// Reset: synchronous, active low; window 64, min gain 0, transform identity,
// totals zero. Row weights hold no reset value and must be loaded first.
// ----------------------------------------------------------------------------
module gf2_greedy_row_reweighter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [grr_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [grr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    grr_item_if.sink                           i_item,
    grr_result_if.source                       o_result
);
    import grr_pkg::*;

    t_cmd    cmd;
    t_status status;

    grr_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    grr_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .o_result   (o_result)
    );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for gf2_greedy_row_reweighter. A queue-fed driver pushes
// weight loads, window starts, candidates and stray items; an item-level
// predictor of the transform rows, row weights and totals builds the expected
// outcome of each candidate, and a monitor compares every result transfer field
// by field. Window size and gain floor are changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import grr_pkg::*;

    localparam logic [OP_BITS-1:0] OP_RESERVED = 2'd3;
    localparam int RANDOM_ITEMS = 800;

    typedef struct packed {
        logic [OP_BITS-1:0]     op;
        logic [ROW_BITS-1:0]    row;
        logic [WEIGHT_BITS-1:0] wt;
        logic [MASK_BITS-1:0]   mask;
        logic [WEIGHT_BITS-1:0] cwt;
    } t_item;

    typedef struct packed {
        logic                   applied;
        logic [ROW_BITS-1:0]    row;
        logic [MASK_BITS-1:0]   xor_src;
        logic [WEIGHT_BITS-1:0] gain;
        logic [TOTAL_BITS-1:0]  app_tot;
        logic [TOTAL_BITS-1:0]  imp_tot;
    } t_outcome;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    grr_item_if   item_ch ();
    grr_result_if result_ch ();

    gf2_greedy_row_reweighter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [MASK_BITS-1:0]   xform_rows [MAX_ROWS];
    logic [WEIGHT_BITS-1:0] row_wt [MAX_ROWS];
    logic [WIN_BITS-1:0]    win_rows;
    logic [WEIGHT_BITS-1:0] gain_floor;
    logic [TOTAL_BITS-1:0]  applied_cnt;
    logic [TOTAL_BITS-1:0]  improve_sum;

    t_item    cmd_backlog [$];
    t_outcome pending_outcomes [$];
    t_item    next_cmd;
    t_item    seen_cmd;
    t_outcome want;
    logic     item_taken;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       fail_count;
    int       stim_count;

    function automatic logic [TOTAL_BITS-1:0] sat_add(input logic [TOTAL_BITS-1:0] a,
                                                      input logic [TOTAL_BITS-1:0] b);
        logic [TOTAL_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_BITS] ? '1 : s[TOTAL_BITS-1:0];
    endfunction

    task automatic predict_reweigh(input t_item it);
        int n;
        int g;
        int best;
        int chosen;
        bit found;
        logic [MASK_BITS-1:0] row_set;
        t_outcome o;
        n = (win_rows > MAX_ROWS) ? MAX_ROWS : int'(win_rows);
        case (it.op)
            OP_LOAD_WEIGHT: row_wt[it.row] = it.wt;
            OP_START_WINDOW: begin
                for (int i = 0; i < MAX_ROWS; i++)
                    xform_rows[i] = (i < n) ? (64'd1 << i) : '0;
                applied_cnt = '0;
                improve_sum = '0;
            end
            OP_CANDIDATE: begin
                row_set = '0;
                for (int i = 0; i < n; i++)
                    row_set[i] = ^(it.mask & xform_rows[i]);
                found = 1'b0;
                best = 0;
                chosen = 0;
                for (int i = 0; i < n; i++) begin
                    if (row_set[i] && row_wt[i] > it.cwt) begin
                        g = int'(row_wt[i]) - int'(it.cwt);
                        if (g >= int'(gain_floor) && (!found || g > best)) begin
                            found = 1'b1;
                            best = g;
                            chosen = i;
                        end
                    end
                end
                o = '0;
                if (found) begin
                    o.applied = 1'b1;
                    o.row = chosen[ROW_BITS-1:0];
                    o.gain = best[WEIGHT_BITS-1:0];
                    o.xor_src = row_set & ~(64'd1 << chosen);
                    row_wt[chosen] = it.cwt;
                    for (int i = 0; i < n; i++)
                        if (o.xor_src[i])
                            xform_rows[i] ^= xform_rows[chosen];
                    applied_cnt = sat_add(applied_cnt, 32'd1);
                    improve_sum = sat_add(improve_sum, TOTAL_BITS'(best));
                end
                o.app_tot = applied_cnt;
                o.imp_tot = improve_sum;
                pending_outcomes.insert(pending_outcomes.size(), o);
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
            result_ch.ready <= 1'b0;
        end else begin
            if (!item_ch.valid || item_taken) begin
                if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_cmd = cmd_backlog.pop_front();
                    item_ch.valid          <= 1'b1;
                    item_ch.operation      <= next_cmd.op;
                    item_ch.row_index      <= next_cmd.row;
                    item_ch.row_weight     <= next_cmd.wt;
                    item_ch.candidate_mask <= next_cmd.mask;
                    item_ch.cand_weight    <= next_cmd.cwt;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_taken <= 1'b0;
        end else begin
            item_taken <= item_ch.valid && item_ch.ready;
            if (item_ch.valid && item_ch.ready) begin
                seen_cmd.op   = item_ch.operation;
                seen_cmd.row  = item_ch.row_index;
                seen_cmd.wt   = item_ch.row_weight;
                seen_cmd.mask = item_ch.candidate_mask;
                seen_cmd.cwt  = item_ch.cand_weight;
                predict_reweigh(seen_cmd);
            end
            if (result_ch.valid && result_ch.ready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result transfer with no outcome pending");
                    fail_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    check_field("applied", 64'(want.applied), 64'(result_ch.applied));
                    check_field("chosen_row", 64'(want.row), 64'(result_ch.chosen_row));
                    check_field("xor_sources", want.xor_src, result_ch.xor_sources);
                    check_field("gain", 64'(want.gain), 64'(result_ch.gain));
                    check_field("applied_total", 64'(want.app_tot),
                                64'(result_ch.applied_total));
                    check_field("improvement_total", 64'(want.imp_tot),
                                64'(result_ch.improvement_total));
                end
            end
        end
    end

    task automatic push_item(input logic [OP_BITS-1:0] op, input int row, input int wt,
                             input logic [MASK_BITS-1:0] mask, input int cwt);
        t_item it;
        it.op = op;
        it.row = row[ROW_BITS-1:0];
        it.wt = wt[WEIGHT_BITS-1:0];
        it.mask = mask;
        it.cwt = cwt[WEIGHT_BITS-1:0];
        cmd_backlog.insert(cmd_backlog.size(), it);
        if (op != OP_RESERVED)
            stim_count++;
    endtask

    task automatic push_load(input int row, input int wt);
        push_item(OP_LOAD_WEIGHT, row, wt, {$urandom, $urandom}, $urandom);
    endtask

    task automatic push_start();
        push_item(OP_START_WINDOW, $urandom, $urandom, {$urandom, $urandom}, $urandom);
    endtask

    task automatic push_cand(input logic [MASK_BITS-1:0] mask, input int cwt);
        push_item(OP_CANDIDATE, $urandom, $urandom, mask, cwt);
    endtask

    task automatic push_noise();
        push_item(OP_BITS'($urandom_range(3)), $urandom, $urandom, {$urandom, $urandom},
                  $urandom);
    endtask

    function automatic logic [MASK_BITS-1:0] make_mask(input int n);
        logic [MASK_BITS-1:0] win_mask;
        logic [MASK_BITS-1:0] m;
        win_mask = (n >= MAX_ROWS) ? '1 : ((64'd1 << n) - 64'd1);
        case ($urandom_range(3))
            0: m = {$urandom, $urandom};
            1: m = 64'd1 << $urandom_range(0, (n > 0) ? n - 1 : 63);
            2: m = {$urandom, $urandom} & win_mask;
            default: begin
                m = '0;
                repeat ($urandom_range(1, 3))
                    m[$urandom_range(0, (n > 0) ? n - 1 : 63)] = 1'b1;
            end
        endcase
        return m;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WINDOW_ROWS)
            win_rows = val[WIN_BITS-1:0];
        else
            gain_floor = val;
    endtask

    task automatic drain();
        while (cmd_backlog.size() != 0 || item_ch.valid || pending_outcomes.size() != 0)
            @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic configure(input int win, input int floor_v);
        drain();
        write_reg(CFG_WINDOW_ROWS, CFG_DATA_BITS'(win));
        write_reg(CFG_MIN_GAIN, CFG_DATA_BITS'(floor_v));
    endtask

    task automatic random_phase();
        int r;
        int win;
        int floor_v;
        int n;
        int wq [$];
        r = $urandom_range(99);
        if (r < 60)      win = $urandom_range(1, 8);
        else if (r < 80) win = $urandom_range(9, 40);
        else if (r < 92) win = MAX_ROWS;
        else if (r < 96) win = $urandom_range(65, 127);
        else             win = 0;
        r = $urandom_range(99);
        if (r < 60)      floor_v = 0;
        else if (r < 85) floor_v = $urandom_range(1, 1500);
        else if (r < 95) floor_v = $urandom_range(1500, 65534);
        else             floor_v = 65535;
        configure(win, floor_v);
        n = (win > MAX_ROWS) ? MAX_ROWS : win;
        if ($urandom_range(99) < 80)
            push_start();
        repeat ($urandom_range(0, 6))
            push_load($urandom_range(0, (n > 0) ? n - 1 : 63), $urandom_range(300, 65535));
        repeat ($urandom_range(8, 30))
            wq.insert(wq.size(), $urandom_range(0, 3000));
        wq.sort();
        foreach (wq[k]) begin
            if ($urandom_range(99) < 12)
                push_noise();
            push_cand(make_mask(n), wq[k]);
        end
    endtask

    initial begin
        #10_000_000;
        $display("** gf2_greedy_row_reweighter: FAILED **");
        $finish;
    end

    initial begin
        int base;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.operation = '0;
        item_ch.row_index = '0;
        item_ch.row_weight = '0;
        item_ch.candidate_mask = '0;
        item_ch.cand_weight = '0;
        result_ch.ready = 1'b0;
        fail_count = 0;
        stim_count = 0;
        send_idle_pct = 18;
        recv_idle_pct = 80;
        win_rows = 7'd64;
        gain_floor = '0;
        applied_cnt = '0;
        improve_sum = '0;
        for (int i = 0; i < MAX_ROWS; i++) begin
            xform_rows[i] = 64'd1 << i;
            row_wt[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // load every row weight before any candidate reads one
        for (int i = 0; i < MAX_ROWS; i++)
            push_load(i, (i == 0) ? 0 : (i == MAX_ROWS - 1) ? 65535 : $urandom_range(1, 65534));

        push_start();
        push_cand('0, 0);
        push_cand('1, 65535);
        push_cand(64'd1, 0);
        push_cand('1, 0);
        push_load(5, 900);
        push_load(9, 900);
        push_start();
        push_cand(64'h220, 100);
        push_cand(64'h200, 100);
        push_item(OP_RESERVED, $urandom, $urandom, {$urandom, $urandom}, $urandom);
        push_load(63, 65535);
        push_load(0, 65535);
        push_cand(64'd1 << 63, 1);
        push_cand({$urandom, $urandom}, 65535);
        push_cand({$urandom, $urandom}, 0);

        configure(1, 65535);
        push_start();
        push_load(0, 65535);
        push_cand('1, 0);
        push_cand('1, 0);

        configure(0, 0);
        push_start();
        push_cand('1, 0);

        configure(8, 0);
        push_start();
        drain();
        write_reg(CFG_WINDOW_ROWS, CFG_DATA_BITS'(16));
        push_cand('1, 50);

        configure(127, 100);
        push_start();
        push_load(2, 600);
        push_cand(64'd1 << 2, 501);
        push_cand(64'd1 << 2, 500);

        base = stim_count;
        while (stim_count < base + RANDOM_ITEMS) begin
            if (stim_count - base < RANDOM_ITEMS / 3) begin
                send_idle_pct = 18;
                recv_idle_pct = 80;
            end else if (stim_count - base < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 80;
                recv_idle_pct = 18;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_phase();
        end

        drain();
        if (fail_count == 0 && pending_outcomes.size() == 0)
            $display("** gf2_greedy_row_reweighter: PASSED **");
        else
            $display("** gf2_greedy_row_reweighter: FAILED **");
        $finish;
    end

endmodule
